[design/icf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_pkg
// shared types and constants of the item-based score engine
// ----------------------------------------------------------------------------
package icf_pkg;

   localparam int ITEM_W      = 6;
   localparam int SIMIN_W     = 16;
   localparam int CFG_W       = 7;
   localparam int SCORE_W     = 22;
   localparam int HELD_W      = 64;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CFG_W-1:0]   NUM_ITEMS_RESET = 7'd64;
   localparam logic [SCORE_W-1:0] SCORE_MAX       = 22'h3FFFFF;

   typedef enum logic [1:0] {
      MODE_SIM_WRITE = 2'd0,
      MODE_CLEAR     = 2'd1,
      MODE_APPEND    = 2'd2,
      MODE_QUERY     = 2'd3
   } mode_type;

   // one classified command waiting for the back end
   typedef struct packed {
      mode_type                kind;
      logic [ITEM_W-1:0]       item;
      logic [ITEM_W-1:0]       nbr;
      logic [SIMIN_W-1:0]      sim;
      logic                    oor;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } back_state_type;

endpackage
`default_nettype wire

[design/icf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module icf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/icf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_queue
// short command fifo between front and back end
// ----------------------------------------------------------------------------
module icf_queue import icf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int QAW = $clog2(QUEUE_DEPTH);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (cnt_ff == (QAW+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

[design/icf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_front
// accepts request transactions, range-checks and classifies them
// ----------------------------------------------------------------------------
module icf_front import icf_pkg::*; #(
   parameter int NUM_ITEMS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [1:0]             req_tuser,
   input  wire logic                   csr_wr_en,
   input  wire logic [CFG_W-1:0]       csr_wr_data,
   input  wire logic                   q_full,
   output logic                        push,
   output cmd_type                     push_cmd
);

   logic [CFG_W-1:0] num_items_ff;
   logic             accept;
   logic             item_ok;
   logic             nbr_ok;
   logic             keep;
   mode_type         mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_items_ff <= NUM_ITEMS_RESET;
      end else if (csr_wr_en) begin
         num_items_ff <= csr_wr_data;
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);

   always_comb begin
      push_cmd.kind = mode;
      push_cmd.item = req_tdata[ITEM_W-1:0];
      push_cmd.nbr  = req_tdata[2*ITEM_W-1:ITEM_W];
      push_cmd.sim  = req_tdata[2*ITEM_W+SIMIN_W-1:2*ITEM_W];
      item_ok       = 32'(push_cmd.item) < 32'(NUM_ITEMS);
      nbr_ok        = 32'(push_cmd.nbr) < 32'(NUM_ITEMS);
      push_cmd.oor  = !item_ok || ({1'b0, push_cmd.item} >= num_items_ff);
   end

   // writes and appends outside the matrix are dropped here
   always_comb begin
      unique case (mode)
         MODE_SIM_WRITE: keep = item_ok && nbr_ok;
         MODE_CLEAR:     keep = 1'b1;
         MODE_APPEND:    keep = item_ok;
         MODE_QUERY:     keep = 1'b1;
         default:        keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

endmodule
`default_nettype wire

[design/icf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icf_back
// executes commands: similarity writes, list updates and score scans
// ----------------------------------------------------------------------------
module icf_back import icf_pkg::*; #(
   parameter int NUM_ITEMS      = 64,
   parameter int MAX_USER_ITEMS = 64,
   parameter int SIM_WIDTH      = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   input  wire cmd_type       cmd,
   output logic               cmd_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [SCORE_W-1:0] rsp_score,
   output logic               rsp_held,
   output logic               rsp_oor
);

   localparam int SIM_DEPTH = NUM_ITEMS * NUM_ITEMS;
   localparam int SIM_AW    = $clog2(SIM_DEPTH);
   localparam int LIST_AW   = (MAX_USER_ITEMS > 1) ? $clog2(MAX_USER_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_USER_ITEMS + 1);
   localparam int ACC_W     = ((SIM_WIDTH > SCORE_W) ? SIM_WIDTH : SCORE_W) + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_USER_ITEMS);

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               p1_ff, p2_ff;
   logic [ITEM_W-1:0]  qitem_ff, qitem_in;
   logic [SCORE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic               rsp_held_ff, rsp_held_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic                 out_free;
   logic                 issue;
   logic                 start_scan;
   logic [ACC_W-1:0]     sum;
   logic                 sim_we;
   logic [SIM_AW-1:0]    sim_waddr, sim_raddr;
   logic [SIM_WIDTH-1:0] sim_rdata;
   logic                 list_we;
   logic [ITEM_W-1:0]    list_rdata;

   icf_ram #(.WIDTH(SIM_WIDTH), .DEPTH(SIM_DEPTH)) u_sim_ram (
      .clock   (clock),
      .wr_en   (sim_we),
      .wr_addr (sim_waddr),
      .wr_data (SIM_WIDTH'(cmd.sim)),
      .rd_addr (sim_raddr),
      .rd_data (sim_rdata)
   );

   icf_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_USER_ITEMS)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (count_ff[LIST_AW-1:0]),
      .wr_data (cmd.item),
      .rd_addr (rd_idx_ff[LIST_AW-1:0]),
      .rd_data (list_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign issue      = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign start_scan = cmd_valid && (cmd.kind == MODE_QUERY) && out_free && !cmd.oor &&
                       !held_ff[cmd.item] && (count_ff != '0);
   assign sim_waddr  = SIM_AW'(cmd.item) * SIM_AW'(NUM_ITEMS) + SIM_AW'(cmd.nbr);
   assign sim_raddr  = SIM_AW'(qitem_ff) * SIM_AW'(NUM_ITEMS) + SIM_AW'(list_rdata);
   assign sum        = ACC_W'(acc_ff) + ACC_W'(sim_rdata);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start_scan) state_in = ST_SCAN;
         ST_SCAN: if (!issue && !p1_ff && !p2_ff) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_pop      = 1'b0;
      sim_we       = 1'b0;
      list_we      = 1'b0;
      count_in     = count_ff;
      held_in      = held_ff;
      rd_idx_in    = issue ? rd_idx_ff + 1'b1 : rd_idx_ff;
      qitem_in     = qitem_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_score_in = rsp_score_ff;
      rsp_held_in  = rsp_held_ff;
      rsp_oor_in   = rsp_oor_ff;

      if (p2_ff) begin
         acc_in = (sum > ACC_W'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  MODE_SIM_WRITE: begin
                     cmd_pop = 1'b1;
                     sim_we  = 1'b1;
                  end
                  MODE_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                     held_in  = '0;
                  end
                  MODE_APPEND: begin
                     cmd_pop = 1'b1;
                     if (count_ff < CNT_MAX) begin
                        list_we  = 1'b1;
                        count_in = count_ff + 1'b1;
                        held_in  = held_ff | (HELD_W'(1) << cmd.item);
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if (cmd.oor || held_ff[cmd.item] || (count_ff == '0)) begin
                           rsp_valid_in = 1'b1;
                           rsp_score_in = '0;
                           rsp_held_in  = !cmd.oor && held_ff[cmd.item];
                           rsp_oor_in   = cmd.oor;
                        end else begin
                           rd_idx_in = '0;
                           acc_in    = '0;
                           qitem_in  = cmd.item;
                        end
                     end
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = acc_ff;
               rsp_held_in  = 1'b0;
               rsp_oor_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         held_ff      <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         p1_ff        <= issue;
         p2_ff        <= p1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      qitem_ff     <= qitem_in;
      acc_ff       <= acc_in;
      rsp_score_ff <= rsp_score_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_held   = rsp_held_ff;
   assign rsp_oor    = rsp_oor_ff;

endmodule
`default_nettype wire

[design/item_cf_score_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// item_cf_score_engine_top
// queries: a query scans the listed items and answers with the summed score;
//   held, out-of-range or empty-list queries answer without a scan
// throughput: one similarity read per listed item per cycle, set by the single
//   read port of the similarity ram
// reset: synchronous, clears list count, held bitmap, num_items to 64;
//   similarity and list rams are not cleared
// ----------------------------------------------------------------------------
module item_cf_score_engine_top import icf_pkg::*; #(
   parameter int NUM_ITEMS      = 64,
   parameter int MAX_USER_ITEMS = 64,
   parameter int SIM_WIDTH      = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // item_index, neighbor_index, similarity
   input  wire logic [1:0]             req_tuser,  // mode
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // score
   output logic [1:0]                  rsp_tuser,  // item_held, out_of_range
   // num_items register
   input  wire logic                   csr_wr_en,
   input  wire logic [CFG_W-1:0]       csr_wr_data
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   // queue to back
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;
   // back end response fields
   logic [SCORE_W-1:0] score;
   logic               item_held;
   logic               out_of_range;

   // front: handshake, range checks against matrix size and num_items
   icf_front #(.NUM_ITEMS(NUM_ITEMS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decouples request acceptance from long scans
   icf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: rams, list state and the scan accumulator
   icf_back #(
      .NUM_ITEMS      (NUM_ITEMS),
      .MAX_USER_ITEMS (MAX_USER_ITEMS),
      .SIM_WIDTH      (SIM_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_score  (score),
      .rsp_held   (item_held),
      .rsp_oor    (out_of_range)
   );

   // pack response transaction
   assign rsp_tdata = {(RSP_TDATA_W-SCORE_W)'(0), score};
   assign rsp_tuser = {out_of_range, item_held};

   // a response never carries both flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("held and out-of-range flags both set");

   // a flagged response carries a zero score
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1])) |-> (rsp_tdata == '0))
      else $error("flagged response with nonzero score");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // queue never overflows: no push when full
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push into full command queue");

endmodule
`default_nettype wire

[dv/item_cf_score_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// item_cf_score_engine_top_test
// self-checking bench for the item-based score engine: a directed table,
// then random list loads, similarity writes and queries over several
// num_items settings, every response checked against the table or an in-bench predictor
// ----------------------------------------------------------------------------
module item_cf_score_engine_top_test import icf_pkg::*; ();

   localparam int CLK_HALF    = 2;
   localparam int CYCLE_LIMIT = 1_000_000;
   // margin for the longest query scan, with room for queued commands
   localparam int SETTLE      = 80;
   localparam int LIST_DEPTH  = 64;

   // expected response fields
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               item_held;
      logic               out_of_range;
   } score_rec;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      mode_type           mode;
      logic [ITEM_W-1:0]  item;
      logic [ITEM_W-1:0]  nbr;
      logic [SIMIN_W-1:0] sim;
      logic               typed;
      score_rec           want;
   } stim_row;

   localparam score_rec NONE = '0;

   localparam stim_row DIRECTED [20] = '{
      // queries right after reset see an empty list
      '{MODE_QUERY,     6'd0,  6'd0,  16'h0000, 1'b1, '{22'd0, 1'b0, 1'b0}},
      '{MODE_QUERY,     6'd63, 6'd63, 16'hFFFF, 1'b1, '{22'd0, 1'b0, 1'b0}},
      // row 5 gets full-scale, half-scale and lsb entries
      '{MODE_SIM_WRITE, 6'd5,  6'd10, 16'hFFFF, 1'b0, NONE},
      '{MODE_SIM_WRITE, 6'd5,  6'd63, 16'h8000, 1'b0, NONE},
      '{MODE_SIM_WRITE, 6'd5,  6'd0,  16'h0001, 1'b0, NONE},
      '{MODE_SIM_WRITE, 6'd63, 6'd0,  16'h1234, 1'b0, NONE},
      // list 10, 63, 0 and 10 again, with junk in the unused fields
      '{MODE_APPEND,    6'd10, 6'd63, 16'hFFFF, 1'b0, NONE},
      '{MODE_APPEND,    6'd63, 6'd0,  16'h0000, 1'b0, NONE},
      '{MODE_APPEND,    6'd0,  6'd21, 16'hA5A5, 1'b0, NONE},
      '{MODE_APPEND,    6'd10, 6'd42, 16'h5A5A, 1'b0, NONE},
      // duplicate counts twice: 2*ffff + 8000 + 1
      '{MODE_QUERY,     6'd5,  6'd0,  16'h0000, 1'b1, '{22'd163839, 1'b0, 1'b0}},
      // held items answer zero with the held flag
      '{MODE_QUERY,     6'd10, 6'd0,  16'h0000, 1'b1, '{22'd0, 1'b1, 1'b0}},
      '{MODE_QUERY,     6'd63, 6'd0,  16'h0000, 1'b1, '{22'd0, 1'b1, 1'b0}},
      '{MODE_QUERY,     6'd0,  6'd0,  16'h0000, 1'b1, '{22'd0, 1'b1, 1'b0}},
      '{MODE_SIM_WRITE, 6'd42, 6'd63, 16'h0000, 1'b0, NONE},
      '{MODE_CLEAR,     6'd33, 6'd17, 16'hFFFF, 1'b0, NONE},
      // after a clear nothing is held and the list is empty
      '{MODE_QUERY,     6'd10, 6'd0,  16'h0000, 1'b1, '{22'd0, 1'b0, 1'b0}},
      '{MODE_APPEND,    6'd0,  6'd0,  16'h0000, 1'b0, NONE},
      '{MODE_QUERY,     6'd63, 6'd0,  16'h0000, 1'b1, '{22'd4660, 1'b0, 1'b0}},
      '{MODE_QUERY,     6'd5,  6'd0,  16'h0000, 1'b0, NONE}
   };

   // ---------------------------------------------------------------- dut ports
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   // item_index, neighbor_index, similarity, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   // mode
   logic [1:0]             req_tuser   = MODE_SIM_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // score, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // item_held, out_of_range
   logic [1:0]             rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   // ---------------------------------------------------------- predictor state
   logic [SIMIN_W-1:0] sim_mem     [64][64];
   bit                 sim_written [64][64];
   logic [ITEM_W-1:0]  user_list   [LIST_DEPTH];
   int                 user_count  = 0;
   logic [HELD_W-1:0]  held_bits   = '0;
   logic [CFG_W-1:0]   cfg_num_items = NUM_ITEMS_RESET;

   score_rec           pending_scores [$];
   int                 errors      = 0;
   int                 cycle_count = 0;
   // set for a stretch in which neither side idles
   logic               calm        = 1'b0;

   item_cf_score_engine_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // hard stop for a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // summed similarity of a candidate over the listed items, saturating
   function automatic score_rec predict_score(input logic [ITEM_W-1:0] cand);
      score_rec   r;
      logic [28:0] acc;
      r = '0;
      if ({1'b0, cand} >= cfg_num_items) begin
         r.out_of_range = 1'b1;
      end else if (held_bits[cand]) begin
         r.item_held = 1'b1;
      end else begin
         acc = '0;
         for (int i = 0; i < user_count; i++) acc += sim_mem[cand][user_list[i]];
         r.score = (acc > SCORE_MAX) ? SCORE_MAX : acc[SCORE_W-1:0];
      end
      return r;
   endfunction

   // random item, mostly inside the active range so queries reach the sum
   function automatic logic [ITEM_W-1:0] pick_item();
      int top;
      top = (cfg_num_items == 0 || cfg_num_items > 64) ? 63 : cfg_num_items - 1;
      if ($urandom_range(3) != 0) return ITEM_W'($urandom_range(top));
      return ITEM_W'($urandom_range(63));
   endfunction

   // ------------------------------------------------------- request driver
   // one transaction: random idle gap, then hold until accepted; valid is
   // left high on exit so back-to-back transactions need no extra edge
   task automatic send_txn(input mode_type m, input logic [ITEM_W-1:0] item,
                           input logic [ITEM_W-1:0] nbr, input logic [SIMIN_W-1:0] sim,
                           input logic typed, input score_rec want);
      while (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {4'b0, sim, nbr, item};
      do @(posedge clock); while (!req_tready);
      // accepted at this edge: advance the predictor
      case (m)
         MODE_SIM_WRITE: begin
            sim_mem[item][nbr]     = sim;
            sim_written[item][nbr] = 1'b1;
         end
         MODE_CLEAR: begin
            user_count = 0;
            held_bits  = '0;
         end
         MODE_APPEND: begin
            // a full list drops the append
            if (user_count < LIST_DEPTH) begin
               user_list[user_count] = item;
               user_count++;
               held_bits[item] = 1'b1;
            end
         end
         MODE_QUERY: pending_scores.push_back(typed ? want : predict_score(item));
      endcase
   endtask

   // make sure every entry a query of cand will sum has been written
   task automatic fill_row(input logic [ITEM_W-1:0] cand, output int sent);
      logic [ITEM_W-1:0] h;
      sent = 0;
      for (int i = 0; i < user_count; i++) begin
         h = user_list[i];
         if (!sim_written[cand][h]) begin
            send_txn(MODE_SIM_WRITE, cand, h, SIMIN_W'($urandom), 1'b0, NONE);
            sent++;
         end
      end
   endtask

   // lower valid, let every query answer, then let the pipe go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_num_items(input logic [CFG_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_num_items = value;
   endtask

   // mostly list loads followed by queries, with loose writes, appends, clears
   task automatic run_random(input int count);
      int                k;
      int                len;
      int                r;
      int                nf;
      logic [ITEM_W-1:0] cand;
      k = 0;
      while (k < count) begin
         r = $urandom_range(99);
         if (r < 12) begin
            // fresh list; now and then long enough to overflow it
            len = ($urandom_range(15) == 0) ? $urandom_range(60, 72) : $urandom_range(8);
            send_txn(MODE_CLEAR, ITEM_W'($urandom), ITEM_W'($urandom),
                     SIMIN_W'($urandom), 1'b0, NONE);
            repeat (len)
               send_txn(MODE_APPEND, pick_item(), ITEM_W'($urandom),
                        SIMIN_W'($urandom), 1'b0, NONE);
            k += len + 1;
         end else if (r < 62) begin
            if (user_count != 0 && $urandom_range(4) == 0)
               cand = user_list[$urandom_range(user_count - 1)];
            else
               cand = pick_item();
            if ({1'b0, cand} < cfg_num_items && !held_bits[cand]) begin
               fill_row(cand, nf);
               k += nf;
            end
            send_txn(MODE_QUERY, cand, ITEM_W'($urandom), SIMIN_W'($urandom), 1'b0, NONE);
            k++;
         end else if (r < 85) begin
            send_txn(MODE_SIM_WRITE, ITEM_W'($urandom), ITEM_W'($urandom),
                     SIMIN_W'($urandom), 1'b0, NONE);
            k++;
         end else if (r < 96) begin
            send_txn(MODE_APPEND, pick_item(), ITEM_W'($urandom),
                     SIMIN_W'($urandom), 1'b0, NONE);
            k++;
         end else begin
            send_txn(MODE_CLEAR, ITEM_W'($urandom), ITEM_W'($urandom),
                     SIMIN_W'($urandom), 1'b0, NONE);
            k++;
         end
      end
   endtask

   // ------------------------------------------------------ response checker
   // handshake sampled with pre-edge values; tready re-rolled every cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $error("response transaction with no query pending");
            errors++;
         end else begin
            score_rec want;
            want = pending_scores.pop_front();
            if (rsp_tdata[SCORE_W-1:0] !== want.score) begin
               $error("score: expected %0d, actual %0d", want.score, rsp_tdata[SCORE_W-1:0]);
               errors++;
            end
            if (rsp_tuser[0] !== want.item_held) begin
               $error("item_held: expected %0d, actual %0d", want.item_held, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== want.out_of_range) begin
               $error("out_of_range: expected %0d, actual %0d",
                      want.out_of_range, rsp_tuser[1]);
               errors++;
            end
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= 35);
   end

   // ---------------------------------------------------------------- main flow
   initial begin
      logic [CFG_W-1:0] settings [6];
      settings[0] = 7'd1;
      settings[1] = 7'd0;
      settings[2] = 7'd127;
      settings[3] = 7'd64;
      settings[4] = CFG_W'($urandom_range(2, 63));
      settings[5] = 7'd33;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset value of num_items
      foreach (DIRECTED[i])
         send_txn(DIRECTED[i].mode, DIRECTED[i].item, DIRECTED[i].nbr, DIRECTED[i].sim,
                  DIRECTED[i].typed, DIRECTED[i].want);
      run_random(130);

      // one phase per num_items setting; the full-range one runs without idling
      for (int p = 0; p < 6; p++) begin
         set_num_items(settings[p]);
         calm <= (p == 3);
         run_random(110);
         calm <= 1'b0;
      end

      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
design/icf_pkg.sv
design/icf_ram.sv
design/icf_queue.sv
design/icf_front.sv
design/icf_back.sv
design/item_cf_score_engine_top.sv
dv/item_cf_score_engine_top_test.sv
